@@ rtl/core/triggered_delay_pulse_generator_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the triggered delay pulse generator core
// Concurrent checks clocked on clk, held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TRIGGERED_DELAY_PULSE_GENERATOR_CORE_ASSERT_SVH
`define TRIGGERED_DELAY_PULSE_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication
`define TDPG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TDPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/tdpg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpg_pkg
// Types and constants shared by the triggered delay pulse generator files.
// ----------------------------------------------------------------------------
package tdpg_pkg;

  localparam int unsigned CNT_W   = 32;  // delay, width and timeout counters
  localparam int unsigned TRY_W   = 16;  // repeat index, sweep step and repeat count registers
  localparam int unsigned CFG_W   = 32;  // widest configuration register
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_ARM    = 3'd1,
    OP_DISARM = 3'd2,
    OP_FIRE   = 3'd3,
    OP_SWEEP  = 3'd4,
    OP_ABORT  = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_DONE      = 3'd1,
    EV_TIMEOUT   = 3'd2,
    EV_NOT_ARMED = 3'd3,
    EV_SWEEP_END = 3'd4,
    EV_ABORTED   = 3'd5
  } event_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_WAIT_A    = 3'd1,
    PH_WAIT_B    = 3'd2,
    PH_DELAY     = 3'd3,
    PH_PULSE     = 3'd4,
    PH_SWEEP_END = 3'd5
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY     = 3'd0,
    CFG_WIDTH     = 3'd1,
    CFG_EDGE_MODE = 3'd2,
    CFG_TIMEOUT   = 3'd3,
    CFG_SW_FIRST  = 3'd4,
    CFG_SW_LAST   = 3'd5,
    CFG_SW_INC    = 3'd6,
    CFG_SW_REPS   = 3'd7
  } cfg_reg_t;

  localparam logic [1:0] MODE_MANUAL = 2'd0;
  localparam logic [1:0] MODE_RISE   = 2'd1;
  localparam logic [1:0] MODE_FALL   = 2'd2;

  // Register reset values
  localparam logic [CNT_W-1:0] RST_DELAY   = 32'd100;
  localparam logic [CNT_W-1:0] RST_WIDTH   = 32'd10;
  localparam logic [CNT_W-1:0] RST_TIMEOUT = 32'd15000000;
  localparam logic [CNT_W-1:0] RST_SW_LAST = 32'd100;
  localparam logic [TRY_W-1:0] RST_SW_INC  = 16'd1;
  localparam logic [TRY_W-1:0] RST_SW_REPS = 16'd1;

  // Zero counts as one
  function automatic logic [CNT_W-1:0] at_least_one(input logic [CNT_W-1:0] v);
    return (v == '0) ? CNT_W'(1) : v;
  endfunction

endpackage

@@ rtl/core/tdpg_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpg_in_if
// Input channel: one item per tick carrying opcode and trigger level.
// ----------------------------------------------------------------------------
interface tdpg_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic       trigger_level;

  modport source (output valid, output opcode, output trigger_level, input ready);
  modport sink   (input valid, input opcode, input trigger_level, output ready);
endinterface

@@ rtl/core/tdpg_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpg_out_if
// Result channel: pulse level, trigger drive, event report and status.
// ----------------------------------------------------------------------------
interface tdpg_out_if;
  logic        valid;
  logic        ready;
  logic        pulse_out;
  logic        trigger_drive;
  logic [2:0]  event_code;
  logic [31:0] event_delay;
  logic [15:0] event_try;
  logic        busy_res;
  logic        armed_flag;

  modport source (output valid, output pulse_out, output trigger_drive, output event_code,
                  output event_delay, output event_try, output busy_res,
                  output armed_flag, input ready);
  modport sink   (input valid, input pulse_out, input trigger_drive, input event_code,
                  input event_delay, input event_try, input busy_res,
                  input armed_flag, output ready);
endinterface

@@ rtl/core/triggered_delay_pulse_generator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triggered_delay_pulse_generator_core
// Armed delay/pulse generator with edge trigger, timeout and delay sweep.
// ----------------------------------------------------------------------------
// Each input item is one tick. The block takes one item per clock cycle while
// the result channel is not stalled, and returns one result item per input
// item: the item lands in an input register, one pass of next-state logic
// (counter decrement, timeout compare, sweep step add and compare) updates the
// state and fills the result register. A stalled result channel holds both
// stages and then drops in_chan.ready. Configuration is written through
// cfg_we / cfg_idx / cfg_wdata and is taken live by the next processed item.
// ----------------------------------------------------------------------------
module triggered_delay_pulse_generator_core
  import tdpg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  tdpg_in_if.sink              in_chan,
  tdpg_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

`include "triggered_delay_pulse_generator_core_assert.svh"

  // Configuration registers
  logic [CNT_W-1:0] delay_r, width_r, timeout_r, sw_first_r, sw_last_r;
  logic [1:0]       edge_mode_r;
  logic [TRY_W-1:0] sw_inc_r, sw_reps_r;

  // Operation state
  phase_t           phase_r, phase_nxt;
  logic             armed_r, armed_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] tmr_r, tmr_nxt;
  logic [CNT_W-1:0] cur_r, cur_nxt;
  logic [TRY_W-1:0] rep_r, rep_nxt;
  logic             swp_r, swp_nxt;

  // Input stage
  logic             s1_v_r;
  opcode_t          s1_op_r;
  logic             s1_lvl_r;

  // Result stage
  logic             out_v_r;
  logic             pulse_r, pulse_nxt;
  logic             tdrv_r, tdrv_nxt;
  event_t           ev_r, ev_nxt;
  logic [CNT_W-1:0] evd_r, evd_nxt;
  logic [TRY_W-1:0] evt_r, evt_nxt;
  logic             busy_r, busy_nxt;
  logic             armf_r, armf_nxt;

  logic in_acc, adv, step_en, manual;

  assign manual  = (edge_mode_r != MODE_RISE) && (edge_mode_r != MODE_FALL);
  assign adv     = !out_v_r || out_chan.ready;
  assign in_chan.ready = !s1_v_r || adv;
  assign in_acc  = in_chan.valid && in_chan.ready;
  assign step_en = s1_v_r && adv;

  // Write configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r     <= RST_DELAY;
      width_r     <= RST_WIDTH;
      edge_mode_r <= MODE_MANUAL;
      timeout_r   <= RST_TIMEOUT;
      sw_first_r  <= '0;
      sw_last_r   <= RST_SW_LAST;
      sw_inc_r    <= RST_SW_INC;
      sw_reps_r   <= RST_SW_REPS;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        CFG_DELAY:     delay_r     <= cfg_wdata;
        CFG_WIDTH:     width_r     <= cfg_wdata;
        CFG_EDGE_MODE: edge_mode_r <= cfg_wdata[1:0];
        CFG_TIMEOUT:   timeout_r   <= cfg_wdata;
        CFG_SW_FIRST:  sw_first_r  <= cfg_wdata;
        CFG_SW_LAST:   sw_last_r   <= cfg_wdata;
        CFG_SW_INC:    sw_inc_r    <= cfg_wdata[TRY_W-1:0];
        CFG_SW_REPS:   sw_reps_r   <= cfg_wdata[TRY_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state: advance the running operation, then apply the opcode
  always_comb begin
    logic             pa, pb, fin, start, was_busy;
    event_t           fin_code;
    logic [CNT_W-1:0] dec;
    logic [TRY_W-1:0] rep_inc;
    logic [TRY_W-1:0] step;
    logic [CNT_W:0]   next_d;

    phase_nxt = phase_r;
    armed_nxt = armed_r;
    cnt_nxt   = cnt_r;
    tmr_nxt   = tmr_r;
    cur_nxt   = cur_r;
    rep_nxt   = rep_r;
    swp_nxt   = swp_r;
    ev_nxt    = EV_NONE;
    evd_nxt   = '0;
    evt_nxt   = '0;
    fin       = 1'b0;
    fin_code  = EV_NONE;
    start     = 1'b0;
    was_busy  = (phase_r != PH_IDLE);
    dec       = (cnt_r != '0) ? cnt_r - CNT_W'(1) : '0;
    pa        = (edge_mode_r != MODE_RISE);
    pb        = (edge_mode_r != MODE_FALL);

    unique case (phase_r)
      PH_WAIT_A, PH_WAIT_B: begin
        if (phase_r == PH_WAIT_B && s1_lvl_r == pb) begin
          phase_nxt = PH_DELAY;
          cnt_nxt   = at_least_one(cur_r);
        end else begin
          if (phase_r == PH_WAIT_A && s1_lvl_r == pa) begin
            phase_nxt = PH_WAIT_B;
          end
          tmr_nxt = (tmr_r != '1) ? tmr_r + CNT_W'(1) : tmr_r;
          if (tmr_nxt >= timeout_r) begin
            fin      = 1'b1;
            fin_code = EV_TIMEOUT;
          end
        end
      end
      PH_DELAY: begin
        if (dec == '0) begin
          phase_nxt = PH_PULSE;
          cnt_nxt   = at_least_one(width_r);
        end else begin
          cnt_nxt = dec;
        end
      end
      PH_PULSE: begin
        cnt_nxt = dec;
        if (dec == '0) begin
          fin      = 1'b1;
          fin_code = EV_DONE;
        end
      end
      PH_SWEEP_END: begin
        phase_nxt = PH_IDLE;
        swp_nxt   = 1'b0;
        ev_nxt    = EV_SWEEP_END;
      end
      default: phase_nxt = PH_IDLE;
    endcase

    // Finish a fire: report, then repeat the point, move to the next sweep point or stop
    rep_inc = rep_r + TRY_W'(1);
    step    = (sw_inc_r == '0) ? TRY_W'(1) : sw_inc_r;
    next_d  = {1'b0, cur_r} + (CNT_W+1)'(step);
    if (fin) begin
      ev_nxt  = fin_code;
      evd_nxt = cur_r;
      evt_nxt = rep_r;
      if (!swp_r) begin
        phase_nxt = PH_IDLE;
      end else if (rep_inc >= sw_reps_r || rep_inc == '0) begin
        rep_nxt = '0;
        if (next_d > {1'b0, sw_last_r}) begin
          phase_nxt = PH_SWEEP_END;
        end else begin
          cur_nxt = next_d[CNT_W-1:0];
          start   = 1'b1;
        end
      end else begin
        rep_nxt = rep_inc;
        start   = 1'b1;
      end
    end

    // Apply the opcode
    case (s1_op_r)
      OP_ARM: armed_nxt = 1'b1;
      OP_DISARM, OP_ABORT: begin
        if (s1_op_r == OP_DISARM) begin
          armed_nxt = 1'b0;
        end
        if (phase_nxt != PH_IDLE || start) begin
          phase_nxt = PH_IDLE;
          swp_nxt   = 1'b0;
          cnt_nxt   = '0;
          tmr_nxt   = '0;
          rep_nxt   = '0;
          start     = 1'b0;
          ev_nxt    = EV_ABORTED;
        end
      end
      OP_FIRE, OP_SWEEP: begin
        if (!was_busy) begin
          if (!armed_r) begin
            ev_nxt = EV_NOT_ARMED;
          end else begin
            rep_nxt = '0;
            if (s1_op_r == OP_FIRE) begin
              swp_nxt = 1'b0;
              cur_nxt = delay_r;
              start   = 1'b1;
            end else if (sw_reps_r == '0 || sw_first_r > sw_last_r) begin
              ev_nxt = EV_SWEEP_END;
            end else begin
              swp_nxt = 1'b1;
              cur_nxt = sw_first_r;
              start   = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase

    // Launch a fire
    if (start) begin
      if (manual) begin
        phase_nxt = PH_DELAY;
        cnt_nxt   = at_least_one(cur_nxt);
      end else begin
        phase_nxt = PH_WAIT_A;
        tmr_nxt   = '0;
      end
    end

    // Fire identity only goes with done or timeout
    if (ev_nxt != EV_DONE && ev_nxt != EV_TIMEOUT) begin
      evd_nxt = '0;
      evt_nxt = '0;
    end
  end

  // Result fields from the new state
  always_comb begin
    pulse_nxt = (phase_nxt == PH_PULSE);
    busy_nxt  = (phase_nxt != PH_IDLE);
    tdrv_nxt  = busy_nxt && manual;
    armf_nxt  = armed_nxt;
  end

  // Hold operation state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      armed_r <= 1'b0;
      cnt_r   <= '0;
      tmr_r   <= '0;
      cur_r   <= '0;
      rep_r   <= '0;
      swp_r   <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      armed_r <= armed_nxt;
      cnt_r   <= cnt_nxt;
      tmr_r   <= tmr_nxt;
      cur_r   <= cur_nxt;
      rep_r   <= rep_nxt;
      swp_r   <= swp_nxt;
    end
  end

  // Input stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (adv) begin
      s1_v_r <= 1'b0;
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r  <= opcode_t'(in_chan.opcode);
      s1_lvl_r <= in_chan.trigger_level;
    end
  end

  // Result stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s1_v_r;
    end
  end

  // Load the result
  always_ff @(posedge clk) begin
    if (step_en) begin
      pulse_r <= pulse_nxt;
      tdrv_r  <= tdrv_nxt;
      ev_r    <= ev_nxt;
      evd_r   <= evd_nxt;
      evt_r   <= evt_nxt;
      busy_r  <= busy_nxt;
      armf_r  <= armf_nxt;
    end
  end

  assign out_chan.valid         = out_v_r;
  assign out_chan.pulse_out     = pulse_r;
  assign out_chan.trigger_drive = tdrv_r;
  assign out_chan.event_code    = ev_r;
  assign out_chan.event_delay   = evd_r;
  assign out_chan.event_try     = evt_r;
  assign out_chan.busy_res      = busy_r;
  assign out_chan.armed_flag    = armf_r;

  // Checks
  `TDPG_ASSERT_NOW(a_busy_needs_armed, phase_r != PH_IDLE, armed_r,
                   "operation running while disarmed")
  `TDPG_ASSERT_NOW(a_sweep_not_idle, swp_r, phase_r != PH_IDLE,
                   "sweep flag set with no operation running")
  `TDPG_ASSERT_NOW(a_ready_only_on_stall, !in_chan.ready,
                   s1_v_r && out_v_r && !out_chan.ready,
                   "input stalled without a blocked result")
  `TDPG_ASSERT_NEXT(a_step_loads_result, step_en, out_v_r,
                    "processed item did not reach the result register")

endmodule

@@ dv/triggered_delay_pulse_generator_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triggered_delay_pulse_generator_core_tb
// Self-checking bench for the triggered delay pulse generator core. Ticks are
// driven with random gaps, every result is checked against a tick-accurate
// model of arming, edge wait, delay, pulse, timeout and delay sweep.
// ----------------------------------------------------------------------------
module triggered_delay_pulse_generator_core_tb;
  import tdpg_pkg::*;

  // Edge mode 3 behaves as manual; opcodes 6 and 7 are plain ticks
  localparam logic [1:0] MODE_ALT_MANUAL = 2'd3;
  localparam logic [2:0] OP_SPARE6       = 3'd6;
  localparam logic [2:0] OP_SPARE7       = 3'd7;
  localparam int         HOLD_CYCLES     = 200;

  typedef struct {
    logic [31:0] delay;
    logic [31:0] width;
    logic [1:0]  mode;
    logic [31:0] timeout;
    logic [31:0] first;
    logic [31:0] last;
    logic [15:0] inc;
    logic [15:0] reps;
  } gen_cfg_t;

  typedef struct {
    logic        pulse;
    logic        trig;
    event_t      ev;
    logic [31:0] ev_delay;
    logic [15:0] ev_try;
    logic        busy;
    logic        armed;
  } tick_result_t;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  tdpg_in_if  in_if ();
  tdpg_out_if out_if ();

  triggered_delay_pulse_generator_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // Generator model state and live register copy
  gen_cfg_t cfg_now = '{RST_DELAY, RST_WIDTH, MODE_MANUAL, RST_TIMEOUT, 32'd0,
                        RST_SW_LAST, RST_SW_INC, RST_SW_REPS};
  phase_t      p_phase     = PH_IDLE;
  logic        p_armed     = 1'b0;
  logic [31:0] p_count     = '0;
  logic [31:0] p_wait      = '0;
  logic [31:0] p_cur_delay = '0;
  logic [15:0] p_try       = '0;
  logic        p_sweeping  = 1'b0;
  logic [31:0] rep_delay;
  logic [15:0] rep_try;

  tick_result_t pending_ticks[$];
  int  err_count;
  int  items_sent;
  int  results_checked;
  int  cfg_loads;
  int  ev_seen[8];
  bit  idle_on = 1'b1;
  bit  long_hold = 1'b0;
  int  rx_wait;
  event hold_start;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // Model
  // ------------------------------------------------------------------------
  function automatic logic [31:0] count_of(input logic [31:0] v);
    return (v == '0) ? 32'd1 : v;
  endfunction

  function automatic logic manual_mode();
    return (cfg_now.mode == MODE_MANUAL) || (cfg_now.mode == MODE_ALT_MANUAL);
  endfunction

  function automatic void launch_fire();
    if (manual_mode()) begin
      p_phase = PH_DELAY;
      p_count = count_of(p_cur_delay);
    end else begin
      p_phase = PH_WAIT_A;
      p_wait  = '0;
    end
  endfunction

  // Report a finished fire and step the sweep, if one runs
  function automatic event_t finish_fire(input event_t code);
    logic [32:0] nxt;
    rep_delay = p_cur_delay;
    rep_try   = p_try;
    if (!p_sweeping) begin
      p_phase = PH_IDLE;
      return code;
    end
    p_try = p_try + 16'd1;
    if (p_try >= cfg_now.reps || p_try == '0) begin
      nxt = {1'b0, p_cur_delay} + ((cfg_now.inc == '0) ? 33'd1 : {17'd0, cfg_now.inc});
      p_try = '0;
      if (nxt > {1'b0, cfg_now.last}) begin
        p_phase = PH_SWEEP_END;
        return code;
      end
      p_cur_delay = nxt[31:0];
    end
    launch_fire();
    return code;
  endfunction

  // Advance the running operation by one tick
  function automatic event_t advance_phase(input logic lvl);
    logic pa;
    logic pb;
    pa = 1'b1;
    pb = 1'b1;
    case (p_phase)
      PH_WAIT_A, PH_WAIT_B: begin
        if (cfg_now.mode == MODE_RISE) begin
          pa = 1'b0;
          pb = 1'b1;
        end else if (cfg_now.mode == MODE_FALL) begin
          pa = 1'b1;
          pb = 1'b0;
        end
        if (p_phase == PH_WAIT_B && lvl == pb) begin
          p_phase = PH_DELAY;
          p_count = count_of(p_cur_delay);
          return EV_NONE;
        end
        if (p_phase == PH_WAIT_A && lvl == pa) p_phase = PH_WAIT_B;
        if (p_wait != '1) p_wait = p_wait + 32'd1;
        if (p_wait >= cfg_now.timeout) return finish_fire(EV_TIMEOUT);
        return EV_NONE;
      end
      PH_DELAY: begin
        if (p_count != '0) p_count = p_count - 32'd1;
        if (p_count == '0) begin
          p_phase = PH_PULSE;
          p_count = count_of(cfg_now.width);
        end
        return EV_NONE;
      end
      PH_PULSE: begin
        if (p_count != '0) p_count = p_count - 32'd1;
        if (p_count == '0) return finish_fire(EV_DONE);
        return EV_NONE;
      end
      PH_SWEEP_END: begin
        p_phase    = PH_IDLE;
        p_sweeping = 1'b0;
        return EV_SWEEP_END;
      end
      default: begin
        p_phase = PH_IDLE;
        return EV_NONE;
      end
    endcase
  endfunction

  // Expected result of one accepted tick
  function automatic tick_result_t predict_tick(input logic [2:0] op, input logic lvl);
    tick_result_t r;
    logic         was_busy;
    event_t       ev;
    was_busy  = (p_phase != PH_IDLE);
    rep_delay = '0;
    rep_try   = '0;
    ev = advance_phase(lvl);
    case (op)
      OP_ARM: p_armed = 1'b1;
      OP_DISARM, OP_ABORT: begin
        if (op == OP_DISARM) p_armed = 1'b0;
        if (p_phase != PH_IDLE) begin
          p_phase    = PH_IDLE;
          p_sweeping = 1'b0;
          p_count    = '0;
          p_wait     = '0;
          p_try      = '0;
          ev         = EV_ABORTED;
        end
      end
      OP_FIRE, OP_SWEEP: begin
        if (!was_busy) begin
          if (!p_armed) begin
            ev = EV_NOT_ARMED;
          end else begin
            p_try = '0;
            if (op == OP_FIRE) begin
              p_sweeping  = 1'b0;
              p_cur_delay = cfg_now.delay;
              launch_fire();
            end else if (cfg_now.reps == '0 || cfg_now.first > cfg_now.last) begin
              ev = EV_SWEEP_END;
            end else begin
              p_sweeping  = 1'b1;
              p_cur_delay = cfg_now.first;
              launch_fire();
            end
          end
        end
      end
      default: ;
    endcase
    if (ev != EV_DONE && ev != EV_TIMEOUT) begin
      rep_delay = '0;
      rep_try   = '0;
    end
    r.pulse    = (p_phase == PH_PULSE);
    r.trig     = (p_phase != PH_IDLE) && manual_mode();
    r.ev       = ev;
    r.ev_delay = rep_delay;
    r.ev_try   = rep_try;
    r.busy     = (p_phase != PH_IDLE);
    r.armed    = p_armed;
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // Drivers
  // ------------------------------------------------------------------------
  // Offer one tick, wait for it to be taken, then record its expected result
  task automatic send_tick(input logic [2:0] op, input logic lvl);
    int gap;
    gap = (idle_on && $urandom_range(0, 1)) ? $urandom_range(1, 15) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.opcode        <= op;
    in_if.trigger_level <= lvl;
    do @(posedge clk); while (!in_if.ready);
    pending_ticks.push_back(predict_tick(op, lvl));
    items_sent++;
  endtask

  // Stop offering and wait until every expected result has come back
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_ticks.size() != 0);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Write all eight registers; junk in the upper bits of the narrow ones
  task automatic load_config(input gen_cfg_t c);
    drain_results();
    write_reg(CFG_DELAY, c.delay);
    write_reg(CFG_WIDTH, c.width);
    write_reg(CFG_EDGE_MODE, {30'($urandom), c.mode});
    write_reg(CFG_TIMEOUT, c.timeout);
    write_reg(CFG_SW_FIRST, c.first);
    write_reg(CFG_SW_LAST, c.last);
    write_reg(CFG_SW_INC, {16'($urandom), c.inc});
    write_reg(CFG_SW_REPS, {16'($urandom), c.reps});
    cfg_we  <= 1'b0;
    cfg_now = c;
    cfg_loads++;
  endtask

  function automatic gen_cfg_t quick_cfg();
    gen_cfg_t c;
    c = '{32'd2, 32'd1, MODE_RISE, 32'd8, 32'd0, 32'd2, 16'd1, 16'd1};
    return c;
  endfunction

  function automatic gen_cfg_t random_cfg();
    gen_cfg_t c;
    c.delay   = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6);
    c.width   = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 4);
    c.mode    = 2'($urandom_range(0, 3));
    c.timeout = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 12);
    c.first   = $urandom_range(0, 3);
    c.last    = $urandom_range(0, 5);
    c.inc     = 16'($urandom_range(0, 3));
    c.reps    = 16'($urandom_range(0, 2));
    if ($urandom_range(0, 7) == 0) begin
      c.first = $urandom;
      c.last  = $urandom;
      c.inc   = 16'($urandom);
    end
    return c;
  endfunction

  // ------------------------------------------------------------------------
  // Result side
  // ------------------------------------------------------------------------
  function automatic void cmp_field(input string fname, input logic [31:0] want,
                                    input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", fname, want, got);
      err_count++;
    end
  endfunction

  task automatic check_result();
    tick_result_t e;
    if (pending_ticks.size() == 0) begin
      $error("result item arrived with no tick outstanding");
      err_count++;
      return;
    end
    e = pending_ticks.pop_front();
    cmp_field("pulse_out", 32'(e.pulse), 32'(out_if.pulse_out));
    cmp_field("trigger_drive", 32'(e.trig), 32'(out_if.trigger_drive));
    cmp_field("event_code", 32'(e.ev), 32'(out_if.event_code));
    cmp_field("event_delay", e.ev_delay, out_if.event_delay);
    cmp_field("event_try", 32'(e.ev_try), 32'(out_if.event_try));
    cmp_field("busy_res", 32'(e.busy), 32'(out_if.busy_res));
    cmp_field("armed_flag", 32'(e.armed), 32'(out_if.armed_flag));
    ev_seen[out_if.event_code]++;
    results_checked++;
  endtask

  // Take results, stall a random number of cycles after each one
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        check_result();
        rx_wait = (idle_on && $urandom_range(0, 1)) ? $urandom_range(1, 15) : 0;
      end
      if (rx_wait > 0) begin
        out_if.ready <= 1'b0;
        rx_wait--;
      end else begin
        out_if.ready <= !long_hold;
      end
    end
  end

  // Long receiver hold-off so the block fills and stalls its input
  initial begin
    forever begin
      @(hold_start);
      @(posedge clk);
      long_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      long_hold <= 1'b0;
    end
  end

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  // Every opcode, not armed, busy commands, a short manual sweep
  task automatic test_directed_ops();
    gen_cfg_t c;
    c = '{32'd0, 32'd0, MODE_MANUAL, 32'd1, 32'd2, 32'd3, 16'd0, 16'd2};
    load_config(c);
    send_tick(OP_FIRE, 1'b0);
    send_tick(OP_SWEEP, 1'b1);
    send_tick(OP_ABORT, 1'b1);
    send_tick(OP_SPARE6, 1'b0);
    send_tick(OP_SPARE7, 1'b1);
    send_tick(OP_ARM, 1'b0);
    send_tick(OP_ARM, 1'b1);
    send_tick(OP_FIRE, 1'b0);
    send_tick(OP_FIRE, 1'b1);
    send_tick(OP_TICK, 1'b0);
    send_tick(OP_SWEEP, 1'b0);
    repeat (14) send_tick(OP_TICK, 1'($urandom_range(0, 1)));
    send_tick(OP_DISARM, 1'b0);
    send_tick(OP_FIRE, 1'b0);
  endtask

  // Rising, falling and the alternate manual code
  task automatic test_edge_trigger();
    gen_cfg_t   c;
    logic [1:0] modes[3] = '{MODE_RISE, MODE_FALL, MODE_ALT_MANUAL};
    logic       pa;
    c = quick_cfg();
    c.timeout = 32'd12;
    foreach (modes[i]) begin
      c.mode = modes[i];
      load_config(c);
      pa = (modes[i] == MODE_FALL);
      send_tick(OP_ARM, ~pa);
      send_tick(OP_FIRE, ~pa);
      send_tick(OP_TICK, ~pa);
      send_tick(OP_TICK, pa);
      send_tick(OP_TICK, pa);
      send_tick(OP_TICK, ~pa);
      repeat (6) send_tick(OP_TICK, 1'($urandom_range(0, 1)));
    end
  endtask

  // Timeout of zero, one, a few ticks and the maximum; edge beats timeout
  task automatic test_timeouts();
    gen_cfg_t    c;
    logic [31:0] limits[4] = '{32'd0, 32'd1, 32'd4, 32'hFFFF_FFFF};
    c = quick_cfg();
    foreach (limits[i]) begin
      c.timeout = limits[i];
      load_config(c);
      send_tick(OP_ARM, 1'b1);
      send_tick(OP_FIRE, 1'b1);
      repeat (6) send_tick(OP_TICK, 1'b1);
      send_tick(OP_ABORT, 1'b1);
    end
    c.timeout = 32'd2;
    load_config(c);
    send_tick(OP_FIRE, 1'b1);
    send_tick(OP_TICK, 1'b0);
    send_tick(OP_TICK, 1'b1);
    repeat (5) send_tick(OP_TICK, 1'b0);
  endtask

  // Largest delay and width, cut short by abort and disarm
  task automatic test_count_extremes();
    gen_cfg_t c;
    c = quick_cfg();
    c.mode  = MODE_MANUAL;
    c.delay = '1;
    c.width = '0;
    load_config(c);
    send_tick(OP_ARM, 1'b0);
    send_tick(OP_FIRE, 1'b0);
    repeat (8) send_tick(OP_TICK, 1'($urandom_range(0, 1)));
    send_tick(OP_ABORT, 1'b0);
    c.delay = '0;
    c.width = '1;
    load_config(c);
    send_tick(OP_FIRE, 1'b1);
    repeat (8) send_tick(OP_TICK, 1'($urandom_range(0, 1)));
    send_tick(OP_DISARM, 1'b1);
    send_tick(OP_FIRE, 1'b0);
  endtask

  // Empty sweeps, sweeps running past 32 bits, many repeats, zero step
  task automatic test_sweeps();
    gen_cfg_t c;
    c = quick_cfg();
    c.reps = '0;
    load_config(c);
    send_tick(OP_ARM, 1'b0);
    send_tick(OP_SWEEP, 1'b0);
    c.reps  = 16'd1;
    c.first = 32'd5;
    c.last  = 32'd4;
    load_config(c);
    send_tick(OP_SWEEP, 1'b1);
    // one timeout per point, then the next point overflows
    c.timeout = 32'd1;
    c.first   = 32'hFFFF_FFF0;
    c.last    = 32'hFFFF_FFFF;
    c.inc     = 16'd5;
    load_config(c);
    send_tick(OP_SWEEP, 1'b1);
    repeat (6) send_tick(OP_TICK, 1'b1);
    c.first = 32'hFFFF_FFFE;
    c.inc   = 16'hFFFF;
    load_config(c);
    send_tick(OP_SWEEP, 1'b1);
    repeat (4) send_tick(OP_TICK, 1'b1);
    c.first = 32'd0;
    c.last  = 32'd0;
    c.reps  = 16'hFFFF;
    load_config(c);
    send_tick(OP_SWEEP, 1'b1);
    repeat (30) send_tick(OP_TICK, 1'b1);
    send_tick(OP_ABORT, 1'b1);
    c = '{32'd7, 32'd0, MODE_MANUAL, 32'd1, 32'd0, 32'd2, 16'd0, 16'd3};
    load_config(c);
    send_tick(OP_SWEEP, 1'b0);
    repeat (30) send_tick(OP_TICK, 1'($urandom_range(0, 1)));
  endtask

  // Edge mode rewritten while a fire waits for its edge
  task automatic test_mode_switch();
    gen_cfg_t c;
    c = quick_cfg();
    c.timeout = 32'd40;
    load_config(c);
    send_tick(OP_ARM, 1'b1);
    send_tick(OP_FIRE, 1'b1);
    send_tick(OP_TICK, 1'b0);
    c.mode = MODE_FALL;
    load_config(c);
    repeat (6) send_tick(OP_TICK, 1'b0);
    c.mode = MODE_RISE;
    load_config(c);
    send_tick(OP_FIRE, 1'b1);
    send_tick(OP_TICK, 1'b1);
    c.mode = MODE_MANUAL;
    load_config(c);
    repeat (7) send_tick(OP_TICK, 1'b1);
  endtask

  // Hold the result side off for a long stretch while ticks keep coming
  task automatic test_backpressure();
    gen_cfg_t c;
    c = '{32'd3, 32'd2, MODE_MANUAL, 32'd8, 32'd0, 32'd3, 16'd1, 16'd2};
    load_config(c);
    idle_on = 1'b0;
    send_tick(OP_ARM, 1'b0);
    -> hold_start;
    send_tick(OP_SWEEP, 1'b0);
    repeat (80) send_tick(OP_TICK, 1'($urandom_range(0, 1)));
    idle_on = 1'b1;
  endtask

  // Mostly well-formed arm/launch/run sequences, some noise in between
  task automatic random_items(input int n);
    int         sent;
    int         steps;
    logic       lvl;
    logic [2:0] op;
    sent = 0;
    lvl  = 1'b0;
    while (sent < n) begin
      if ($urandom_range(0, 9) < 8) begin
        if (!p_armed) begin
          send_tick(OP_ARM, lvl);
          sent++;
        end
        send_tick(($urandom_range(0, 9) < 7) ? OP_FIRE : OP_SWEEP, lvl);
        sent++;
        steps = 0;
        while (p_phase != PH_IDLE && steps < 150) begin
          if ($urandom_range(0, 2) == 0) lvl = ~lvl;
          if ($urandom_range(0, 39) == 0) op = 3'($urandom_range(0, 7));
          else op = OP_TICK;
          send_tick(op, lvl);
          sent++;
          steps++;
        end
        if (p_phase != PH_IDLE) begin
          send_tick(OP_ABORT, lvl);
          sent++;
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_tick(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
          sent++;
        end
      end
    end
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 8; ph++) begin
      load_config(random_cfg());
      idle_on = (ph != 3);
      random_items(80);
    end
    idle_on = 1'b1;
  endtask

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------
  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = CFG_DELAY;
    cfg_wdata           = '0;
    in_if.valid         = 1'b0;
    in_if.opcode        = OP_TICK;
    in_if.trigger_level = 1'b0;
    out_if.ready        = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_ops();
    test_edge_trigger();
    test_timeouts();
    test_count_extremes();
    test_sweeps();
    test_mode_switch();
    test_backpressure();
    test_random();

    drain_results();
    repeat (10) @(posedge clk);

    $display("Summary: %0d ticks sent, %0d results checked, %0d register settings",
             items_sent, results_checked, cfg_loads);
    $display("Events: done %0d, timeout %0d, not armed %0d, sweep end %0d, aborted %0d",
             ev_seen[EV_DONE], ev_seen[EV_TIMEOUT], ev_seen[EV_NOT_ARMED],
             ev_seen[EV_SWEEP_END], ev_seen[EV_ABORTED]);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
